// ===== rtl/dll_pkg.sv =====
// ----------------------------------------------------------------------------
// dll_pkg: shared types and constants of the linked list manager
// Node and list counts, operation codes, request and response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package dll_pkg;

  localparam int NumNodes = 64;
  localparam int NumLists = 4;
  localparam int NodeW    = $clog2(NumNodes);
  localparam int PtrW     = NodeW + 1;
  localparam int ListW    = 2;
  localparam int OwnerW   = 3;

  localparam logic [PtrW-1:0] NodeNone = PtrW'(NumNodes);

  typedef enum logic [3:0] {
    OP_INIT       = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_PUSH_FRONT = 4'd2,
    OP_PUSH_BACK  = 4'd3,
    OP_INS_BEFORE = 4'd4,
    OP_INS_AFTER  = 4'd5,
    OP_POP_FRONT  = 4'd6,
    OP_POP_BACK   = 4'd7,
    OP_REMOVE     = 4'd8,
    OP_FRONT      = 4'd9,
    OP_BACK       = 4'd10,
    OP_NEXT       = 4'd11,
    OP_PREV       = 4'd12,
    OP_SIZE       = 4'd13,
    OP_IS_LINKED  = 4'd14
  } op_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [ListW-1:0] list_id;
    logic [5:0]       node_index;
    logic [5:0]       position_index;
  } req_t;

  typedef struct packed {
    logic       ok;
    logic [6:0] result_node;
    logic [6:0] list_count;
    logic       node_linked;
  } rsp_t;

  // One node entry: prev pointer, next pointer, owner (list plus one)
  typedef struct packed {
    logic [PtrW-1:0]   prev;
    logic [PtrW-1:0]   next;
    logic [OwnerW-1:0] owner;
  } node_t;

endpackage

`default_nettype wire

// ===== rtl/dll_if.sv =====
// ----------------------------------------------------------------------------
// dll_req_if / dll_rsp_if: valid/ready channels of the list manager
// Request channel and response channel with payload structs.
// ----------------------------------------------------------------------------
`default_nettype none

interface dll_req_if;
  logic          valid;
  logic          ready;
  dll_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dll_rsp_if;
  logic          valid;
  logic          ready;
  dll_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/doubly_linked_list_manager.sv =====
// ----------------------------------------------------------------------------
// doubly_linked_list_manager: node pool threaded into several linked lists
// Node prev/next/owner live in a single-port-read memory; list heads,
// tails, lengths and ready flags live in flip-flops.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   req     | in  | kind, list_id, node_index, position_index
//   rsp     | out | ok, result_node, list_count, node_linked
//
// One request at a time. Queries and refused requests answer after the
// node_index and position_index reads; links and removes go on to read
// and write the neighbors (one memory read per pointer fetched, one write
// per node); pops then run a remove pass (the target is fetched again).
// Init and clear sweep the node memory. After reset a sweep frees every
// node; no request is taken then. A waiting response holds until taken; rsp stalls block req.
// ----------------------------------------------------------------------------
`default_nettype none

module doubly_linked_list_manager (
  input wire logic    clk,
  input wire logic    rst,
  dll_req_if.sink     req,
  dll_rsp_if.source   rsp
);

  localparam int NodeW = dll_pkg::NodeW;
  localparam int PtrW  = dll_pkg::PtrW;

  typedef enum logic [3:0] {
    S_RSTCLR, S_IDLE, S_RD_N, S_RD_P, S_EVAL, S_RD_NB, S_WR_A, S_WR_B,
    S_WR_N, S_SWEEP, S_SWEEP_W, S_RESP
  } state_t;

  state_t state;

  // list registers
  logic [PtrW-1:0] head   [dll_pkg::NumLists];
  logic [PtrW-1:0] tail   [dll_pkg::NumLists];
  logic [6:0]      length [dll_pkg::NumLists];
  logic [dll_pkg::NumLists-1:0] lready;

  // request and working registers
  dll_pkg::req_t   r;
  dll_pkg::node_t  nent;   // entry of node_index
  logic [PtrW-1:0] a_ptr, b_ptr, tgt;
  logic            do_link;
  logic            pop_pass; // remove pass of a pop is running
  logic [NodeW:0]  sweep;
  dll_pkg::rsp_t   out;

  // memory port
  logic            we;
  logic [NodeW-1:0] waddr, raddr;
  dll_pkg::node_t  wdata, rdata;

  dll_node_mem u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [dll_pkg::OwnerW-1:0] own_l;
  assign own_l = dll_pkg::OwnerW'(r.list_id) + 1'b1;

  logic rdy;
  assign rdy = lready[r.list_id];

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RESP);
  assign rsp.data  = out;

  // write and read port control; S_RD_N fetches node_index
  always_comb begin
    we    = 1'b0;
    waddr = r.node_index;
    wdata = '{prev: dll_pkg::NodeNone, next: dll_pkg::NodeNone, owner: '0};
    raddr = r.node_index;
    case (state)
      S_RSTCLR: begin
        we = 1'b1; waddr = sweep[NodeW-1:0];
      end
      S_RD_P:   raddr = r.position_index;
      S_RD_NB:  raddr = a_ptr[NodeW-1:0];
      S_SWEEP:  raddr = sweep[NodeW-1:0];
      S_SWEEP_W: begin
        waddr = sweep[NodeW-1:0];
        raddr = sweep[NodeW-1:0] + 1'b1;
        we    = (rdata.owner == own_l);
      end
      S_WR_A: begin
        // a.next update (link: n, unlink: b)
        waddr = a_ptr[NodeW-1:0];
        raddr = b_ptr[NodeW-1:0];
        we    = !a_ptr[NodeW];
        wdata = rdata;
        wdata.next = do_link ? PtrW'(r.node_index) : b_ptr;
      end
      S_WR_B: begin
        waddr = b_ptr[NodeW-1:0];
        we    = !b_ptr[NodeW];
        wdata = rdata;
        wdata.prev = do_link ? PtrW'(r.node_index) : a_ptr;
      end
      S_WR_N: begin
        we    = 1'b1;
        waddr = tgt[NodeW-1:0];
        if (do_link) wdata = '{prev: a_ptr, next: b_ptr, owner: own_l};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RSTCLR;
      sweep    <= '0;
      lready   <= '0;
      pop_pass <= 1'b0;
      for (int i = 0; i < dll_pkg::NumLists; i++) begin
        head[i] <= dll_pkg::NodeNone; tail[i] <= dll_pkg::NodeNone; length[i] <= '0;
      end
    end else begin
      case (state)
        S_RSTCLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (NodeW+1)'(dll_pkg::NumNodes - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          r        <= req.data;
          pop_pass <= 1'b0;
          state    <= S_RD_N;
        end
        S_RD_N: state <= S_RD_P;
        S_RD_P: begin
          nent  <= rdata;
          state <= S_EVAL;
        end
        S_EVAL: begin
          // fresh response, kept as is through the remove pass of a pop
          if (!pop_pass) begin
            out <= '{ok: 1'b0, result_node: dll_pkg::NodeNone,
                     list_count: length[r.list_id], node_linked: (nent.owner != '0)};
          end
          state <= S_RESP;
          case (r.kind)
            dll_pkg::OP_INIT, dll_pkg::OP_CLEAR: begin
              if (r.kind == dll_pkg::OP_INIT || rdy) begin
                sweep <= '0;
                state <= S_SWEEP;
              end
            end
            dll_pkg::OP_PUSH_FRONT, dll_pkg::OP_PUSH_BACK: begin
              if (rdy && nent.owner == '0) begin
                do_link <= 1'b1; tgt <= PtrW'(r.node_index);
                a_ptr <= (r.kind == dll_pkg::OP_PUSH_FRONT) ? dll_pkg::NodeNone
                         : tail[r.list_id];
                b_ptr <= (r.kind == dll_pkg::OP_PUSH_FRONT) ? head[r.list_id]
                         : dll_pkg::NodeNone;
                state <= S_RD_NB;
              end
            end
            dll_pkg::OP_INS_BEFORE, dll_pkg::OP_INS_AFTER: begin
              if (rdy && nent.owner == '0 && rdata.owner == own_l) begin
                do_link <= 1'b1; tgt <= PtrW'(r.node_index);
                a_ptr <= (r.kind == dll_pkg::OP_INS_BEFORE) ? rdata.prev
                         : PtrW'(r.position_index);
                b_ptr <= (r.kind == dll_pkg::OP_INS_BEFORE) ? PtrW'(r.position_index)
                         : rdata.next;
                state <= S_RD_NB;
              end
            end
            dll_pkg::OP_POP_FRONT, dll_pkg::OP_POP_BACK: begin
              // target pointers come from a fresh read of the target
              if (rdy) begin
                tgt <= (r.kind == dll_pkg::OP_POP_FRONT) ? head[r.list_id]
                       : tail[r.list_id];
                if (((r.kind == dll_pkg::OP_POP_FRONT) ? head[r.list_id]
                     : tail[r.list_id]) != dll_pkg::NodeNone) begin
                  do_link  <= 1'b0;
                  pop_pass <= 1'b1;
                  r.node_index <= (r.kind == dll_pkg::OP_POP_FRONT)
                                  ? head[r.list_id][NodeW-1:0] : tail[r.list_id][NodeW-1:0];
                  state <= S_RD_N;
                  r.kind <= dll_pkg::OP_REMOVE;
                  out.result_node <= (r.kind == dll_pkg::OP_POP_FRONT) ? head[r.list_id]
                                     : tail[r.list_id];
                  // the addressed node is unlinked if it is the one popped
                  out.node_linked <= (nent.owner != '0) &&
                                     (r.node_index != ((r.kind == dll_pkg::OP_POP_FRONT)
                                      ? head[r.list_id][NodeW-1:0]
                                      : tail[r.list_id][NodeW-1:0]));
                end
              end
            end
            dll_pkg::OP_REMOVE: begin
              if (rdy && nent.owner == own_l) begin
                do_link <= 1'b0; tgt <= PtrW'(r.node_index);
                a_ptr <= nent.prev; b_ptr <= nent.next;
                state <= S_RD_NB;
              end
            end
            default: ;
          endcase
          // queries
          case (r.kind)
            dll_pkg::OP_FRONT, dll_pkg::OP_BACK: begin
              if (rdy && ((r.kind == dll_pkg::OP_FRONT) ? head[r.list_id]
                          : tail[r.list_id]) != dll_pkg::NodeNone) begin
                out.ok <= 1'b1;
                out.result_node <= (r.kind == dll_pkg::OP_FRONT) ? head[r.list_id]
                                   : tail[r.list_id];
              end
            end
            dll_pkg::OP_NEXT, dll_pkg::OP_PREV: begin
              if (rdy && nent.owner != '0 &&
                  ((r.kind == dll_pkg::OP_NEXT) ? nent.next : nent.prev)
                  != dll_pkg::NodeNone) begin
                out.ok <= 1'b1;
                out.result_node <= (r.kind == dll_pkg::OP_NEXT) ? nent.next : nent.prev;
              end
            end
            dll_pkg::OP_SIZE:      out.ok <= rdy;
            dll_pkg::OP_IS_LINKED: out.ok <= (nent.owner != '0);
            default: ;
          endcase
        end
        // read the a neighbor; its entry arrives in S_WR_A, which reads b
        S_RD_NB: state <= S_WR_A;
        S_WR_A: begin
          if (a_ptr[NodeW]) begin
            head[r.list_id] <= do_link ? PtrW'(r.node_index) : b_ptr;
          end
          state <= S_WR_B;
        end
        S_WR_B: begin
          if (b_ptr[NodeW]) begin
            tail[r.list_id] <= do_link ? PtrW'(r.node_index) : a_ptr;
          end
          state <= S_WR_N;
        end
        S_WR_N: begin
          length[r.list_id] <= do_link ? length[r.list_id] + 1'b1
                               : length[r.list_id] - 1'b1;
          out.ok          <= 1'b1;
          out.list_count  <= do_link ? length[r.list_id] + 1'b1
                             : length[r.list_id] - 1'b1;
          out.node_linked <= do_link ? 1'b1 : (pop_pass && out.node_linked);
          state <= S_RESP;
        end
        S_SWEEP: state <= S_SWEEP_W;
        S_SWEEP_W: begin
          if (sweep == (NodeW+1)'(dll_pkg::NumNodes - 1)) begin
            head[r.list_id]   <= dll_pkg::NodeNone;
            tail[r.list_id]   <= dll_pkg::NodeNone;
            length[r.list_id] <= '0;
            lready[r.list_id] <= 1'b1;
            out.ok            <= 1'b1;
            out.list_count    <= '0;
            out.node_linked   <= out.node_linked && (nent.owner != own_l);
            state <= S_RESP;
          end
          sweep <= sweep + 1'b1;
        end
        S_RESP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dll_node_mem.sv =====
// ----------------------------------------------------------------------------
// dll_node_mem: node table memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dll_node_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [dll_pkg::NodeW-1:0]  waddr,
  input  wire dll_pkg::node_t             wdata,
  input  wire logic [dll_pkg::NodeW-1:0]  raddr,
  output dll_pkg::node_t                  rdata
);

  dll_pkg::node_t mem [dll_pkg::NumNodes];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
